### src/hbs3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs3_pkg: shared types and constants for the 3x3 heightmap box smoother
// Field widths, register indexes and the divide-by-nine reciprocal.
// ----------------------------------------------------------------------------
package hbs3_pkg;

  localparam int HEIGHT_BITS    = 18;
  localparam int GRID_W_BITS    = 13;
  localparam int GRID_H_BITS    = 16;
  localparam int ROW_BITS       = GRID_H_BITS + 1;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [GRID_W_BITS-1:0] GRID_W_RESET = 13'd4096;
  localparam logic [GRID_H_BITS-1:0] GRID_H_RESET = 16'd4096;

  localparam logic [0:0] FUNC_SAMPLE = 1'b0;
  localparam logic [0:0] FUNC_FLUSH  = 1'b1;

  // nine samples summed exactly
  localparam int SUM_BITS     = HEIGHT_BITS + 4;
  // floor(x / 9) = (x * DIV_MUL) >> DIV_SHIFT, exact for all SUM_BITS values
  localparam int DIV_SHIFT    = SUM_BITS + 4;
  localparam int DIV_MUL_BITS = DIV_SHIFT - 3;
  localparam logic [DIV_MUL_BITS-1:0] DIV_MUL =
    DIV_MUL_BITS'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
  localparam int PROD_BITS    = SUM_BITS + DIV_MUL_BITS;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_ctl_t;

endpackage

### src/hbs3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs3_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module hbs3_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/heightmap_box_smooth_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_box_smooth_3x3_core: one pass of 3x3 box smoothing on a height grid
// Raster-order samples in, smoothed or passed-through samples out.
// ----------------------------------------------------------------------------
// Takes one sample and gives one result per clock in steady state, unless stalled.
// A sample is read against the line store (one RAM holding the two previous
// rows side by side) in the cycle it is accepted, the column sum is formed
// as the read data returns and the row and column entry is written back,
// then the nine-sample sum and a reciprocal multiply for the divide by nine
// follow, so a result passes the s1, s2 and s3 stages into the output
// register. Results trail samples by one grid row plus one sample;
// after the last sample, send (clamped) grid_width+1 flush beats to drain them. Flush
// beats that arrive before the grid is complete are dropped. Any register
// write restarts the grid and must only be done while the block is idle.
// Both input channels are held off during reset. The line store needs no
// clearing after reset.
module heightmap_box_smooth_3x3_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hbs3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [hbs3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic                                  func,
  input  logic [hbs3_pkg::HEIGHT_BITS-1:0]      height_in,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [hbs3_pkg::HEIGHT_BITS-1:0]      height_out,
  output logic                                  last_sample
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int HB       = hbs3_pkg::HEIGHT_BITS;
  localparam int SB       = hbs3_pkg::SUM_BITS;
  localparam int RB       = hbs3_pkg::ROW_BITS;

  // configuration
  logic [hbs3_pkg::GRID_W_BITS-1:0] grid_width;
  logic [hbs3_pkg::GRID_H_BITS-1:0] grid_height;
  logic [COL_BITS-1:0]              w_last;
  logic [hbs3_pkg::GRID_H_BITS-1:0] h_eff;
  logic [RB-1:0]                    h_ext;
  logic                             cfg_write;

  // raster position
  logic [COL_BITS-1:0] col, col_next;
  logic [RB-1:0]       row, row_next;
  logic                draining;
  logic                accept;
  logic                item_go;
  hbs3_pkg::item_ctl_t ctl_in;

  // pipeline
  logic                s1_v, s2_v, s3_v;
  logic                s1_adv, s2_adv, s3_adv;
  logic                s1_take, s2_take, s3_take, out_take;
  logic [COL_BITS-1:0] s1_col;
  logic [HB-1:0]       s1_val;
  hbs3_pkg::item_ctl_t s1_ctl, s2_ctl, s3_ctl;

  logic [2*HB-1:0]     rd_data;
  logic [HB-1:0]       rd_a, rd_b;
  logic [SB-1:0]       col_sum_new;
  logic [SB-1:0]       csum0, csum1, csum2;
  logic [SB-1:0]       total;
  logic [HB-1:0]       prev_a;
  logic [HB-1:0]       s2_pass, s3_pass;
  logic [hbs3_pkg::PROD_BITS-1:0] s3_prod;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    if (grid_width < 13'd3) begin
      w_last = COL_BITS'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(grid_width - 13'd1);
    end
    h_eff = (grid_height < 16'd3) ? 16'd3 : grid_height;
    h_ext = {1'b0, h_eff};
  end

  // handshake: each stage moves when the next one is empty or moving
  assign out_take     = !result_valid || !result_stall;
  assign s3_take      = !s3_v || out_take;
  assign s2_take      = !s2_v || s3_take;
  assign s1_take      = !s1_v || s2_take;
  assign sample_stall = rst || !s1_take;
  assign s1_adv       = s1_v && s2_take;
  assign s2_adv       = s2_v && s3_take;
  assign s3_adv       = s3_v && out_take;

  assign accept   = sample_valid && !sample_stall;
  assign draining = row >= h_ext;
  // early flush beats are swallowed
  assign item_go  = accept && !((func == hbs3_pkg::FUNC_FLUSH) && !draining);

  always_comb begin
    ctl_in.emit     = (row >= RB'(2)) || ((row == RB'(1)) && (col != '0));
    ctl_in.interior = (row >= RB'(2)) && (row < h_ext) && (col >= COL_BITS'(2));
    ctl_in.last     = (row == h_ext + RB'(1)) && (col == '0);

    col_next = col + COL_BITS'(1);
    row_next = row;
    if (ctl_in.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col == w_last) begin
      col_next = '0;
      row_next = row + RB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= hbs3_pkg::GRID_W_RESET;
      grid_height <= hbs3_pkg::GRID_H_RESET;
      col         <= '0;
      row         <= '0;
    end else if (cfg_write) begin
      if (cfg_index == hbs3_pkg::REG_GRID_WIDTH) begin
        grid_width <= cfg_data[hbs3_pkg::GRID_W_BITS-1:0];
        col        <= '0;
        row        <= '0;
      end else if (cfg_index == hbs3_pkg::REG_GRID_HEIGHT) begin
        grid_height <= cfg_data[hbs3_pkg::GRID_H_BITS-1:0];
        col         <= '0;
        row         <= '0;
      end
    end else if (item_go) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line store entry holds {row above, two rows above} for one column.
  // same column recurs only every grid_width >= 3 beats, and a stalled
  // write-back blocks new reads; the one exception is column 0 right after
  // a grid end, where the stale two-rows-above half is overwritten in row 1
  // before any result uses it
  hbs3_ram #(
    .WIDTH (2 * HB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({s1_val, rd_a}),
    .re    (item_go),
    .raddr (col),
    .rdata (rd_data)
  );

  assign rd_a        = rd_data[2*HB-1:HB];
  assign rd_b        = rd_data[HB-1:0];
  assign col_sum_new = SB'(rd_a) + SB'(rd_b) + SB'(s1_val);
  assign total       = csum0 + csum1 + csum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_go) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2_v <= 1'b1;
      end else if (s2_adv) begin
        s2_v <= 1'b0;
      end
      // items that give no result leave the pipe here
      if (s2_adv) begin
        s3_v <= s2_ctl.emit;
      end else if (s3_adv) begin
        s3_v <= 1'b0;
      end
      if (s3_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      s1_col <= col;
      s1_val <= draining ? '0 : height_in;
      s1_ctl <= ctl_in;
    end
    // window kept as three column sums; center and right-border tail both
    // equal the middle-row sample of the previous beat
    if (s1_adv) begin
      csum0   <= csum1;
      csum1   <= csum2;
      csum2   <= col_sum_new;
      s2_pass <= prev_a;
      prev_a  <= rd_a;
      s2_ctl  <= s1_ctl;
    end
    if (s2_adv) begin
      s3_prod <= hbs3_pkg::PROD_BITS'(total) * hbs3_pkg::PROD_BITS'(hbs3_pkg::DIV_MUL);
      s3_pass <= s2_pass;
      s3_ctl  <= s2_ctl;
    end
    if (s3_adv) begin
      height_out  <= s3_ctl.interior ? s3_prod[hbs3_pkg::DIV_SHIFT +: HB] : s3_pass;
      last_sample <= s3_ctl.last;
    end
  end

endmodule

### src/hbs3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs3_checker: port-level checks for the 3x3 heightmap box smoother
// Watches handshakes and result ordering on the top level ports.
// ----------------------------------------------------------------------------
module hbs3_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic [hbs3_pkg::HEIGHT_BITS-1:0]    height_out,
  input logic                                last_sample
);

  // a held result beat stays up
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(height_out) && $stable(last_sample))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a full pipe behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled with output free");

  // a grid holds at least nine samples, so grid ends never come back to back
  a_last_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && last_sample |=> !(result_valid && last_sample))
    else $error("two grid-end beats in a row");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_box_smooth_3x3_core hbs3_checker u_hbs3_checker (.*);
